// ===== rtl/rlrv_pkg.sv =====
package rlrv_pkg;

    localparam int TIME_W      = 63;
    localparam int PRICE_W     = 32;
    localparam int RET_W       = 32;
    localparam int VOL_W       = 32;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 8;
    localparam int FRAC_W      = 30;
    localparam int LOG_W       = FRAC_W + 5;
    localparam int SQ_W        = 64;
    localparam int FRAC_ROUNDS = 30;
    localparam int SQ_SHIFT    = 12;
    localparam int VAR_SHIFT   = 8;

    localparam logic [27:0] LN2_Q28 = 28'd186065279;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDEWAYS = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRENDING = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLATILE = 8'd3;

    localparam logic [CFG_W-1:0] WINDOW_RESET   = 32'd60000000;
    localparam logic [CFG_W-1:0] SIDEWAYS_RESET = 32'd16777;
    localparam logic [CFG_W-1:0] TRENDING_RESET = 32'd50332;
    localparam logic [CFG_W-1:0] VOLATILE_RESET = 32'd167772;

    typedef enum logic [1:0] {
        REGIME_SIDEWAYS,
        REGIME_TRENDING,
        REGIME_VOLATILE,
        REGIME_SPIKE
    } regime_t;

    typedef enum logic [1:0] {
        JOB_HOLD,
        JOB_FIRST,
        JOB_PUSH
    } job_kind_t;

    typedef struct packed {
        job_kind_t          kind;
        logic [TIME_W-1:0]  stamp;
        logic [RET_W-1:0]   ret;
    } job_t;

    typedef struct packed {
        logic [TIME_W-1:0]  stamp;
        logic [RET_W-1:0]   ret;
    } entry_t;

    typedef struct packed {
        logic [CFG_W-1:0] window_us;
        logic [CFG_W-1:0] threshold_sideways;
        logic [CFG_W-1:0] threshold_trending;
        logic [CFG_W-1:0] threshold_volatile;
    } cfg_t;

endpackage

// ===== rtl/rlrv_if.sv =====
interface rlrv_sample_if import rlrv_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [TIME_W-1:0]   sample_time;
    logic [PRICE_W-1:0]  sample_price;

    modport source (output valid, output sample_time, output sample_price, input ready);
    modport sink   (input valid, input sample_time, input sample_price, output ready);
endinterface

interface rlrv_result_if import rlrv_pkg::*; #(parameter int CNT_W = 9) ();
    logic              valid;
    logic              ready;
    logic [VOL_W-1:0]  volatility;
    logic [1:0]        regime;
    logic [CNT_W-1:0]  stored_count;

    modport source (output valid, output volatility, output regime, output stored_count,
                    input ready);
    modport sink   (input valid, input volatility, input regime, input stored_count,
                    output ready);
endinterface

interface rlrv_cfg_if import rlrv_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/rlrv_ram.sv =====
module rlrv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  logic [WIDTH-1:0]          wdata,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/rlrv_fifo.sv =====
module rlrv_fifo import rlrv_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  job_t  wdata,
    output logic  full,
    input  logic  pop,
    output job_t  rdata,
    output logic  empty
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    job_t            mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;

    assign full  = (count_reg == (PW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if ((push && !full) && !(pop && !empty))
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/rlrv_front.sv =====
module rlrv_front import rlrv_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    rlrv_sample_if.sink    sample,
    output job_t           job,
    output logic           job_push,
    input  logic           job_full
);

    typedef enum logic [2:0] {
        F_IDLE,
        F_NORM,
        F_LOG,
        F_DIFF,
        F_MUL,
        F_PUSH
    } state_t;

    state_t              state_reg;
    job_kind_t           kind_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [PRICE_W-1:0]  price_reg;
    logic [31:0]         m_reg;
    logic [4:0]          p_reg;
    logic [FRAC_W-1:0]   frac_reg;
    logic [4:0]          round_reg;
    logic [LOG_W-1:0]    prev_log_reg;
    logic                prev_valid_reg;
    logic [LOG_W-1:0]    d_reg;
    logic                neg_reg;
    logic [RET_W-1:0]    ret_reg;

    logic [4:0]          p_find;
    logic [63:0]         m_sq;
    logic [32:0]         m_scaled;
    logic [31:0]         m_next;
    logic                frac_bit;
    logic [LOG_W-1:0]    cur_log;
    logic                log_neg;
    logic [LOG_W-1:0]    log_diff;
    logic [63:0]         ln_prod;
    logic [30:0]         ret_mag;

    always_comb
    begin
        p_find = '0;
        for (int i = 0; i < PRICE_W; i++)
        begin
            if (price_reg[i])
            begin
                p_find = 5'(i);
            end
        end
    end

    // One squaring round of the mantissa yields one fraction bit of log2.
    assign m_sq     = 64'(m_reg) * 64'(m_reg);
    assign m_scaled = m_sq[63:31];
    assign frac_bit = m_scaled[32];
    assign m_next   = frac_bit ? m_scaled[32:1] : m_scaled[31:0];

    assign cur_log  = {p_reg, frac_reg};
    assign log_neg  = (cur_log < prev_log_reg);
    assign log_diff = log_neg ? (prev_log_reg - cur_log) : (cur_log - prev_log_reg);

    assign ln_prod  = 64'(d_reg) * 64'(LN2_Q28) + 64'h8000_0000;
    assign ret_mag  = ln_prod[62:32];

    assign sample.ready = (state_reg == F_IDLE);
    assign job_push     = (state_reg == F_PUSH) && !job_full;
    assign job.kind     = kind_reg;
    assign job.stamp    = time_reg;
    assign job.ret      = ret_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            kind_reg       <= JOB_HOLD;
            prev_valid_reg <= 1'b0;
            round_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (sample.valid)
                    begin
                        time_reg  <= sample.sample_time;
                        price_reg <= sample.sample_price;
                        if (sample.sample_price == '0)
                        begin
                            kind_reg  <= JOB_HOLD;
                            state_reg <= F_PUSH;
                        end
                        else
                        begin
                            state_reg <= F_NORM;
                        end
                    end
                end
                F_NORM:
                begin
                    m_reg     <= price_reg << (5'd31 - p_find);
                    p_reg     <= p_find;
                    frac_reg  <= '0;
                    round_reg <= '0;
                    state_reg <= F_LOG;
                end
                F_LOG:
                begin
                    m_reg     <= m_next;
                    frac_reg  <= {frac_reg[FRAC_W-2:0], frac_bit};
                    round_reg <= round_reg + 1'b1;
                    if (round_reg == 5'(FRAC_ROUNDS - 1))
                    begin
                        if (prev_valid_reg)
                        begin
                            state_reg <= F_DIFF;
                        end
                        else
                        begin
                            kind_reg  <= JOB_FIRST;
                            state_reg <= F_PUSH;
                        end
                    end
                end
                F_DIFF:
                begin
                    d_reg     <= log_diff;
                    neg_reg   <= log_neg;
                    state_reg <= F_MUL;
                end
                F_MUL:
                begin
                    ret_reg   <= neg_reg ? (32'd0 - {1'b0, ret_mag}) : {1'b0, ret_mag};
                    kind_reg  <= JOB_PUSH;
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!job_full)
                    begin
                        if (kind_reg != JOB_HOLD)
                        begin
                            prev_log_reg   <= cur_log;
                            prev_valid_reg <= 1'b1;
                        end
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/rlrv_back.sv =====
module rlrv_back import rlrv_pkg::*; #(
    parameter int RING_DEPTH = 256,
    parameter int CNT_W      = 9
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    input  job_t            job,
    input  logic            job_empty,
    output logic            job_pop,
    rlrv_result_if.source   result
);

    localparam int AW    = $clog2(RING_DEPTH);
    localparam int SUM_W = RET_W + AW;

    typedef enum logic [3:0] {
        B_IDLE,
        B_EXP_RD,
        B_EXP_CHK,
        B_DROP,
        B_INS_SQ,
        B_INS_WR,
        B_VAR,
        B_DIV_MEAN,
        B_M2,
        B_DIV_E2,
        B_SUBV,
        B_SQRT,
        B_DONE
    } state_t;

    state_t                    state_reg;
    logic [TIME_W-1:0]         stamp_reg;
    logic [RET_W-1:0]          ret_reg;
    logic [AW-1:0]             oldest_reg;
    logic [AW-1:0]             next_reg;
    logic [CNT_W-1:0]          count_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [SQ_W-1:0]           sqsum_reg;
    logic                      force_reg;
    logic [63:0]               prod_reg;
    logic [RET_W-1:0]          drop_ret_reg;
    logic [63:0]               dvd_reg;
    logic [CNT_W-1:0]          rem_reg;
    logic [5:0]                iter_reg;
    logic [63:0]               srem_reg;
    logic [63:0]               root_reg;
    logic [63:0]               bit_reg;
    logic [VOL_W-1:0]          vol_reg;
    logic                      res_valid_reg;
    logic [VOL_W-1:0]          res_vol_reg;
    regime_t                   res_regime_reg;
    logic [CNT_W-1:0]          res_count_reg;

    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t                    rd_entry;
    logic                      ram_we;
    logic [RET_W-1:0]          mul_a;
    logic [63:0]               prod;
    logic                      expired;
    logic [SUM_W-1:0]          sum_mag;
    logic [CNT_W:0]            trial;
    logic                      div_ge;
    logic [CNT_W-1:0]          rem_next;
    logic [63:0]               dvd_next;
    logic [63:0]               m2;
    logic [63:0]               sq_try;
    logic                      sq_ge;
    logic [63:0]               root_next;
    regime_t                   regime;
    logic                      out_free;

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] slot);
        return (slot == AW'(RING_DEPTH - 1)) ? '0 : slot + 1'b1;
    endfunction

    function automatic logic [RET_W-1:0] ret_abs(input logic [RET_W-1:0] r);
        return r[RET_W-1] ? (RET_W'(0) - r) : r;
    endfunction

    function automatic logic signed [SUM_W-1:0] ret_sext(input logic [RET_W-1:0] r);
        return {{(SUM_W-RET_W){r[RET_W-1]}}, r};
    endfunction

    rlrv_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (next_reg),
        .wdata ({stamp_reg, ret_reg}),
        .raddr (oldest_reg),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);
    assign ram_we   = (state_reg == B_INS_WR);
    assign job_pop  = (state_reg == B_IDLE) && !job_empty;

    // One shared multiplier: return squares on insert and evict, and the mean squared.
    always_comb
    begin
        case (state_reg)
            B_INS_SQ:  mul_a = ret_abs(ret_reg);
            B_EXP_CHK: mul_a = ret_abs(rd_entry.ret);
            B_M2:      mul_a = dvd_reg[31:0];
            default:   mul_a = '0;
        endcase
    end
    assign prod = 64'(mul_a) * 64'(mul_a);

    assign expired = ({1'b0, rd_entry.stamp} + 64'(cfg.window_us)) < {1'b0, stamp_reg};
    assign sum_mag = sum_reg[SUM_W-1] ? (SUM_W'(0) - SUM_W'(sum_reg)) : SUM_W'(sum_reg);

    // Restoring division by the entry count, one quotient bit a cycle.
    assign trial    = {rem_reg, dvd_reg[63]};
    assign div_ge   = (trial >= {1'b0, count_reg});
    assign rem_next = div_ge ? CNT_W'(trial - {1'b0, count_reg}) : CNT_W'(trial);
    assign dvd_next = {dvd_reg[62:0], div_ge};

    assign m2 = prod_reg >> SQ_SHIFT;

    assign sq_try    = root_reg + bit_reg;
    assign sq_ge     = (srem_reg >= sq_try);
    assign root_next = sq_ge ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);

    always_comb
    begin
        if (vol_reg < cfg.threshold_sideways)
        begin
            regime = REGIME_SIDEWAYS;
        end
        else if (vol_reg < cfg.threshold_trending)
        begin
            regime = REGIME_TRENDING;
        end
        else if (vol_reg < cfg.threshold_volatile)
        begin
            regime = REGIME_VOLATILE;
        end
        else
        begin
            regime = REGIME_SPIKE;
        end
    end

    assign out_free            = !res_valid_reg || result.ready;
    assign result.valid        = res_valid_reg;
    assign result.volatility   = res_vol_reg;
    assign result.regime       = res_regime_reg;
    assign result.stored_count = res_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            oldest_reg    <= '0;
            next_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            sqsum_reg     <= '0;
            force_reg     <= 1'b0;
            iter_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            // In B_DONE the output register is reloaded below instead.
            if (res_valid_reg && result.ready && (state_reg != B_DONE))
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (!job_empty)
                    begin
                        stamp_reg <= job.stamp;
                        ret_reg   <= job.ret;
                        case (job.kind)
                            JOB_FIRST:
                            begin
                                force_reg <= 1'b0;
                                state_reg <= B_EXP_RD;
                            end
                            JOB_PUSH:
                            begin
                                if (count_reg == CNT_W'(RING_DEPTH))
                                begin
                                    force_reg <= 1'b1;
                                    state_reg <= B_EXP_RD;
                                end
                                else
                                begin
                                    state_reg <= B_INS_SQ;
                                end
                            end
                            default:
                            begin
                                state_reg <= B_VAR;
                            end
                        endcase
                    end
                end
                B_EXP_RD:
                begin
                    state_reg <= (count_reg == '0) ? B_VAR : B_EXP_CHK;
                end
                B_EXP_CHK:
                begin
                    if (force_reg || expired)
                    begin
                        prod_reg     <= prod;
                        drop_ret_reg <= rd_entry.ret;
                        state_reg    <= B_DROP;
                    end
                    else
                    begin
                        state_reg <= B_VAR;
                    end
                end
                B_DROP:
                begin
                    sum_reg    <= sum_reg - ret_sext(drop_ret_reg);
                    sqsum_reg  <= sqsum_reg - (prod_reg >> SQ_SHIFT);
                    oldest_reg <= advance(oldest_reg);
                    count_reg  <= count_reg - 1'b1;
                    if (force_reg)
                    begin
                        force_reg <= 1'b0;
                        state_reg <= B_INS_SQ;
                    end
                    else
                    begin
                        state_reg <= B_EXP_RD;
                    end
                end
                B_INS_SQ:
                begin
                    prod_reg  <= prod;
                    state_reg <= B_INS_WR;
                end
                B_INS_WR:
                begin
                    sum_reg   <= sum_reg + ret_sext(ret_reg);
                    sqsum_reg <= sqsum_reg + (prod_reg >> SQ_SHIFT);
                    next_reg  <= advance(next_reg);
                    count_reg <= count_reg + 1'b1;
                    state_reg <= B_EXP_RD;
                end
                B_VAR:
                begin
                    if (count_reg < CNT_W'(2))
                    begin
                        vol_reg   <= '0;
                        state_reg <= B_DONE;
                    end
                    else
                    begin
                        dvd_reg   <= 64'(sum_mag);
                        rem_reg   <= '0;
                        iter_reg  <= '0;
                        state_reg <= B_DIV_MEAN;
                    end
                end
                B_DIV_MEAN:
                begin
                    dvd_reg  <= dvd_next;
                    rem_reg  <= rem_next;
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == 6'd63)
                    begin
                        state_reg <= B_M2;
                    end
                end
                B_M2:
                begin
                    // The mean magnitude never exceeds the largest return, so 32 bits hold it.
                    prod_reg  <= prod;
                    dvd_reg   <= sqsum_reg;
                    rem_reg   <= '0;
                    iter_reg  <= '0;
                    state_reg <= B_DIV_E2;
                end
                B_DIV_E2:
                begin
                    dvd_reg  <= dvd_next;
                    rem_reg  <= rem_next;
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == 6'd63)
                    begin
                        state_reg <= B_SUBV;
                    end
                end
                B_SUBV:
                begin
                    if (dvd_reg <= m2)
                    begin
                        vol_reg   <= '0;
                        state_reg <= B_DONE;
                    end
                    else
                    begin
                        srem_reg  <= (dvd_reg - m2) << VAR_SHIFT;
                        root_reg  <= '0;
                        bit_reg   <= 64'd1 << 62;
                        iter_reg  <= '0;
                        state_reg <= B_SQRT;
                    end
                end
                B_SQRT:
                begin
                    if (sq_ge)
                    begin
                        srem_reg <= srem_reg - sq_try;
                    end
                    root_reg <= root_next;
                    bit_reg  <= bit_reg >> 2;
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == 6'd31)
                    begin
                        vol_reg   <= root_next[VOL_W-1:0];
                        state_reg <= B_DONE;
                    end
                end
                B_DONE:
                begin
                    if (out_free)
                    begin
                        res_valid_reg  <= 1'b1;
                        res_vol_reg    <= vol_reg;
                        res_regime_reg <= regime;
                        res_count_reg  <= count_reg;
                        state_reg      <= B_IDLE;
                    end
                    else
                    begin
                        res_valid_reg <= res_valid_reg;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/rolling_log_return_volatility.sv =====
// Flow: the front end queues a zero price directly and a nonzero one after 30 squaring rounds
// of the log2 mantissa and, once a previous price is held, a difference and a multiply; the back
// end then evicts or expires entries, runs two 64-step divisions and a 32-step square root, and
// holds its result until it is taken. The front end takes the next request once its job is
// queued and works on it while the back end is busy with the last one.
// Reset: asynchronous, active low; clears counts, sums, pointers, queue and the previous price,
// and loads the default window and thresholds; ring contents stay undefined until written.
module rolling_log_return_volatility import rlrv_pkg::*; #(
    parameter int RING_DEPTH = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    rlrv_sample_if.sink     sample,
    rlrv_result_if.source   result,
    rlrv_cfg_if.sink        cfg
);

    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    cfg_t  cfg_reg;
    job_t  q_wdata;
    job_t  q_rdata;
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_us          <= WINDOW_RESET;
            cfg_reg.threshold_sideways <= SIDEWAYS_RESET;
            cfg_reg.threshold_trending <= TRENDING_RESET;
            cfg_reg.threshold_volatile <= VOLATILE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_WINDOW:   cfg_reg.window_us          <= cfg.data;
                CFG_SIDEWAYS: cfg_reg.threshold_sideways <= cfg.data;
                CFG_TRENDING: cfg_reg.threshold_trending <= cfg.data;
                CFG_VOLATILE: cfg_reg.threshold_volatile <= cfg.data;
                default:      ;
            endcase
        end
    end

    rlrv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample),
        .job      (q_wdata),
        .job_push (q_push),
        .job_full (q_full)
    );

    rlrv_fifo u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    rlrv_back #(
        .RING_DEPTH (RING_DEPTH),
        .CNT_W      (CNT_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job       (q_rdata),
        .job_empty (q_empty),
        .job_pop   (q_pop),
        .result    (result)
    );

    a_few_returns_no_vol: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.stored_count < CNT_W'(2))) |-> (result.volatility == '0))
        else $error("volatility nonzero with fewer than two stored returns");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.stored_count <= CNT_W'(RING_DEPTH)))
        else $error("stored count beyond ring depth");

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into a full queue");

    a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> !sample.ready)
        else $error("front end took a request while busy");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import rlrv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 256;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int SETTLE      = 1200;

    typedef struct {
        logic [VOL_W-1:0] volatility;
        regime_t          regime;
        logic [8:0]       stored_count;
    } vol_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rlrv_sample_if smp ();
    rlrv_result_if #(.CNT_W(9)) res ();
    rlrv_cfg_if cfg_ch ();

    rolling_log_return_volatility #(.RING_DEPTH(DEPTH)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (smp),
        .result (res),
        .cfg    (cfg_ch)
    );

    always #5 clk = ~clk;

    // Shadow state of the block.
    logic [TIME_W-1:0] ring_stamp [DEPTH];
    logic [RET_W-1:0]  ring_ret [DEPTH];
    int                head_slot;
    int                tail_slot;
    int                held;
    longint            ret_sum;
    logic [63:0]       sq_sum;
    logic [31:0]       last_price;
    logic [31:0]       win_us;
    logic [31:0]       thr_side;
    logic [31:0]       thr_trend;
    logic [31:0]       thr_vol;

    vol_report_t pending_reports[$];
    int          errors = 0;
    longint      cycles = 0;

    logic [TIME_W-1:0] walk_time;
    logic [31:0]       walk_price;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic logic [63:0] log2_fixed(input logic [31:0] x);
        int p;
        logic [63:0] m;
        logic [63:0] frac;
        p = 31;
        frac = 0;
        while (p > 0 && !x[p]) p--;
        m = 64'(x) << (31 - p);
        for (int i = 0; i < FRAC_ROUNDS; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac = frac | 64'd1;
                m = m >> 1;
            end
        end
        return (64'(p) << 30) | frac;
    endfunction

    function automatic logic [31:0] log_ratio(input logic [31:0] now_p, input logic [31:0] old_p);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] d;
        logic [63:0] q;
        a = log2_fixed(now_p);
        b = log2_fixed(old_p);
        d = (a < b) ? b - a : a - b;
        q = (d * 64'(LN2_Q28) + 64'h8000_0000) >> 32;
        return (a < b) ? 32'(0) - q[31:0] : q[31:0];
    endfunction

    function automatic logic [63:0] square_q40(input logic [31:0] r);
        longint s;
        logic [63:0] m;
        s = longint'($signed(r));
        m = (s < 0) ? 64'(-s) : 64'(s);
        return (m * m) >> SQ_SHIFT;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bit_w;
        rem = v;
        root = 0;
        bit_w = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= root + bit_w) begin
                rem = rem - (root + bit_w);
                root = (root >> 1) + bit_w;
            end else begin
                root = root >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return root;
    endfunction

    task automatic drop_oldest_return();
        ret_sum -= longint'($signed(ring_ret[head_slot]));
        sq_sum -= square_q40(ring_ret[head_slot]);
        head_slot = (head_slot + 1) % DEPTH;
        held--;
    endtask

    function automatic logic [31:0] current_volatility();
        logic [63:0] mag;
        logic [63:0] mean;
        logic [63:0] m2;
        logic [63:0] e2;
        logic [63:0] root;
        if (held < 2) return 0;
        mag = (ret_sum < 0) ? 64'(-ret_sum) : 64'(ret_sum);
        mean = mag / 64'(held);
        m2 = (mean * mean) >> SQ_SHIFT;
        e2 = sq_sum / 64'(held);
        if (e2 <= m2) return 0;
        root = int_sqrt((e2 - m2) << VAR_SHIFT);
        return root[31:0];
    endfunction

    task automatic predict_volatility(input logic [TIME_W-1:0] t, input logic [31:0] p);
        vol_report_t rep;
        logic [31:0] r;
        if (p != 0) begin
            if (last_price != 0) begin
                r = log_ratio(p, last_price);
                if (held >= DEPTH) drop_oldest_return();
                ring_stamp[tail_slot] = t;
                ring_ret[tail_slot] = r;
                tail_slot = (tail_slot + 1) % DEPTH;
                ret_sum += longint'($signed(r));
                sq_sum += square_q40(r);
                held++;
            end
            last_price = p;
            while (held > 0 && ({1'b0, ring_stamp[head_slot]} + 64'(win_us)) < {1'b0, t})
                drop_oldest_return();
        end
        rep.volatility = current_volatility();
        if (rep.volatility < thr_side) rep.regime = REGIME_SIDEWAYS;
        else if (rep.volatility < thr_trend) rep.regime = REGIME_TRENDING;
        else if (rep.volatility < thr_vol) rep.regime = REGIME_VOLATILE;
        else rep.regime = REGIME_SPIKE;
        rep.stored_count = 9'(held);
        pending_reports.push_back(rep);
    endtask

    task automatic send_sample(input logic [TIME_W-1:0] t, input logic [31:0] p);
        int gap;
        gap = $urandom_range(0, 10);
        if (gap > 0) begin
            smp.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        smp.valid <= 1'b1;
        smp.sample_time <= t;
        smp.sample_price <= p;
        do @(posedge clk); while (!smp.ready);
        predict_volatility(t, p);
    endtask

    task automatic wait_idle();
        @(posedge clk);
        smp.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            CFG_WINDOW:   win_us = val;
            CFG_SIDEWAYS: thr_side = val;
            CFG_TRENDING: thr_trend = val;
            CFG_VOLATILE: thr_vol = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] w, input logic [31:0] s,
                              input logic [31:0] tr, input logic [31:0] v);
        wait_idle();
        write_reg(CFG_WINDOW, w);
        write_reg(CFG_SIDEWAYS, s);
        write_reg(CFG_TRENDING, tr);
        write_reg(CFG_VOLATILE, v);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random walk of time and price, with occasional noise and broken sequences.
    task automatic send_walk(input int count, input int max_step, input int shift);
        logic [31:0] p;
        longint delta;
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) walk_time = 63'({$urandom(), $urandom()});
            else if (pick < 4) walk_time = walk_time - 63'($urandom_range(0, max_step));
            else walk_time = walk_time + 63'($urandom_range(0, max_step));
            if (pick >= 96) begin
                p = 0;
            end else if (pick >= 93) begin
                p = $urandom();
                if (p == 0) p = 1;
                walk_price = p;
            end else begin
                delta = longint'(walk_price >> shift) * longint'($urandom_range(0, 200)) / 100;
                if ($urandom_range(0, 1)) delta = -delta;
                delta = longint'(walk_price) + delta;
                if (delta < 1) delta = 1;
                if (delta > 64'hFFFF_FFFF) delta = 64'hFFFF_FFFF;
                walk_price = 32'(delta);
                p = walk_price;
            end
            send_sample(walk_time, p);
        end
    endtask

    task automatic test_directed_extremes();
        send_sample(63'd0, 32'd0);
        send_sample(63'd5, 32'h0001_0000);
        send_sample(63'd10, 32'h0001_0000);
        send_sample(63'd20, 32'hFFFF_FFFF);
        send_sample(63'd30, 32'd1);
        send_sample(63'd40, 32'd0);
        send_sample(63'd50, 32'hFFFF_FFFF);
        send_sample(63'd60, 32'h8000_0000);
        send_sample(63'd70, 32'h7FFF_FFFF);
        send_sample(63'd80, 32'h0001_0001);
        send_sample(63'd90, 32'h0001_0000);
        send_sample({1'b0, {62{1'b1}}}, 32'h0002_0000);
        send_sample({63{1'b1}}, 32'h0003_0000);
        send_sample({63{1'b1}}, 32'h0003_1000);
        send_sample(63'd100, 32'h0002_8000);
        send_sample(63'd100, 32'd0);
    endtask

    task automatic test_short_window();
        set_config(32'd1000, 32'd1000, 32'd100000, 32'd5000000);
        walk_time = 63'd1000;
        walk_price = 32'h0064_0000;
        send_walk(200, 300, 6);
    endtask

    task automatic test_zero_window();
        set_config(32'd0, 32'd0, 32'd0, 32'd0);
        send_walk(60, 3, 4);
        send_sample(walk_time, 32'h0010_0000);
        send_sample(walk_time, 32'h0011_0000);
        send_sample(walk_time, 32'h0012_0000);
    endtask

    task automatic test_unordered_thresholds();
        set_config(32'hFFFF_FFFF, 32'd300000, 32'd1000, 32'hFFFF_FFFF);
        send_walk(80, 1000, 3);
        set_config(32'hFFFF_FFFF, $urandom(), $urandom(), $urandom());
        send_walk(60, 1000, 5);
        wait_idle();
        write_reg(8'd7, 32'hFFFF_FFFF);
        write_reg(8'hFF, 32'd0);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_ring_wrap();
        set_config(32'hFFFF_FFFF, SIDEWAYS_RESET, TRENDING_RESET, VOLATILE_RESET);
        walk_time = 63'd0;
        walk_price = 32'h1000_0000;
        send_walk(320, 1000, 8);
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < 4; ph++) begin
            set_config($urandom_range(1, 200000), $urandom_range(0, 60000),
                       $urandom_range(0, 200000), $urandom_range(0, 2000000));
            send_walk(120, 20000, $urandom_range(2, 10));
        end
        set_config(WINDOW_RESET, SIDEWAYS_RESET, TRENDING_RESET, VOLATILE_RESET);
        send_walk(100, 2_000_000, 7);
    endtask

    // Result side: random stalls, each accepted result checked in order.
    initial begin
        int gap;
        vol_report_t want;
        res.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            gap = $urandom_range(0, 10);
            if (gap > 0) begin
                res.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res.ready <= 1'b1;
            do @(posedge clk); while (!(res.valid && res.ready));
            if (pending_reports.size() == 0) begin
                report_mismatch("unexpected result", longint'(res.volatility), 64'd0);
            end else begin
                want = pending_reports.pop_front();
                if (res.volatility !== want.volatility)
                    report_mismatch("volatility", longint'(res.volatility),
                                    longint'(want.volatility));
                if (res.regime !== want.regime)
                    report_mismatch("regime", longint'(res.regime), longint'(want.regime));
                if (res.stored_count !== want.stored_count)
                    report_mismatch("stored_count", longint'(res.stored_count),
                                    longint'(want.stored_count));
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL rolling_log_return_volatility");
            $finish;
        end
    end

    initial begin
        smp.valid = 1'b0;
        smp.sample_time = '0;
        smp.sample_price = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        head_slot = 0;
        tail_slot = 0;
        held = 0;
        ret_sum = 0;
        sq_sum = 0;
        last_price = 0;
        win_us = WINDOW_RESET;
        thr_side = SIDEWAYS_RESET;
        thr_trend = TRENDING_RESET;
        thr_vol = VOLATILE_RESET;
        walk_time = 0;
        walk_price = 32'h0001_0000;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_short_window();
        test_zero_window();
        test_unordered_thresholds();
        test_ring_wrap();
        test_random_settings();

        wait_idle();
        if (errors == 0 && pending_reports.size() == 0)
            $display("PASS rolling_log_return_volatility");
        else
            $display("FAIL rolling_log_return_volatility");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/rlrv_pkg.sv
rtl/rlrv_if.sv
rtl/rlrv_ram.sv
rtl/rlrv_fifo.sv
rtl/rlrv_front.sv
rtl/rlrv_back.sv
rtl/rolling_log_return_volatility.sv
tb/tb_top.sv
